@@ rtl/core/mrect_pkg.sv @@
package mrect_pkg;

  // fixed field widths
  localparam int CFG_W  = 7;
  localparam int AREA_W = 13;

  localparam logic [AREA_W-1:0] AREA_MAX       = 13'd8191;
  localparam logic [CFG_W-1:0]  NUM_COLS_RESET = 7'd64;

  // default sizes
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // height store control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } hmem_ctl_t;

endpackage

@@ rtl/core/mrect_if.sv @@
// cell input channel
interface mrect_cell_if
  import mrect_pkg::*;
;
  logic valid;
  logic ready;
  logic cell_req;
  logic last_cell;

  modport source (output valid, output cell_req, output last_cell, input ready);
  modport sink   (input valid, input cell_req, input last_cell, output ready);
endinterface

// area result channel
interface mrect_area_if
  import mrect_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] max_area;

  modport source (output valid, output max_area, input ready);
  modport sink   (input valid, input max_area, output ready);
endinterface

// column count write channel
interface mrect_cfg_if
  import mrect_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_cols;

  modport source (output valid, output num_cols, input ready);
  modport sink   (input valid, input num_cols, output ready);
endinterface

@@ rtl/core/mrect_hmem.sv @@
module mrect_hmem
  import mrect_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS,
  parameter int AW    = $clog2(DEF_MAX_COLS),
  parameter int DW    = $clog2(DEF_MAX_ROWS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  hmem_ctl_t     ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data,
  output logic          busy
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] sweep;

  // clearing pass after reset or on request
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      if (sweep == AW'(DEPTH - 1)) begin
        busy  <= 1'b0;
        sweep <= '0;
      end else begin
        sweep <= sweep + 1'b1;
      end
    end else if (ctl.clear) begin
      busy  <= 1'b1;
      sweep <= '0;
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/mrect_smem.sv @@
module mrect_smem
  import mrect_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS,
  parameter int AW    = $clog2(DEF_MAX_COLS),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // stack entries, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/max_rectangle_of_ones.sv @@
// Largest all-ones rectangle in a binary matrix.
// cells: one beat per matrix cell in row-major order (cell_req, last_cell).
// result: one beat carrying max_area for each beat with last_cell set.
// cfg: writes num_cols (0 acts as 1, above MAX_COLS acts as MAX_COLS);
// always ready, to be written only while the block is idle.
// Per cell the block reads and writes back the column height, after which
// the next cell is taken. The cell that closes a row then scans
// the row's heights from the height memory with the monotonic stack: a
// start step, a push per column, a pop that goes through the stack memory
// read when there is an entry below the top, a bottom pop and a finishing
// step. Every column is pushed and popped once per row. After the scan of
// the last row the block waits in S_OUT for the output register to empty,
// then registers the result beat.
// After reset and after each last cell the height memory is cleared, one
// column per cycle, during which cells is not ready.
// A result held by a stalled receiver does not block further cells; only
// the next last cell waits for the output register to empty.
module max_rectangle_of_ones
  import mrect_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic   clk,
  input  logic   rst,
  mrect_cell_if.sink   cells,
  mrect_area_if.source result,
  mrect_cfg_if.sink    cfg
);

  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int IW = $clog2(MAX_COLS);
  localparam int SW = IW + HW;
  localparam int PW = HW + CW;
  localparam int XW = (PW > AREA_W) ? PW : AREA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDH  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_RDS  = 3'd6;

  logic [2:0]        state;
  logic [CFG_W-1:0]  num_cols;
  logic [IW-1:0]     column_pos;
  logic [IW-1:0]     pos;
  logic              cell_val;
  logic              last;
  logic              row_end;
  logic              drain;
  logic [CW-1:0]     cur_i;
  logic [CW-1:0]     row_n;
  logic [HW-1:0]     cur_h;
  logic [CW-1:0]     cnt;
  logic [HW-1:0]     top_h;
  logic [PW-1:0]     prod;
  logic              prod_valid;
  logic [AREA_W-1:0] best;
  logic              out_valid;
  logic [AREA_W-1:0] out_area;

  logic [CW-1:0]     cols;
  logic [CW-1:0]     cols_m1;
  logic [IW-1:0]     pos_c;
  logic [CW-1:0]     pos_c_p1;
  logic [CW-1:0]     pos_p1;
  logic              accept;
  logic              pop_cond;
  logic              push;
  logic              more;
  logic [CW-1:0]     nxt_i;
  logic [CW-1:0]     cnt_m2;
  logic [CW-1:0]     pop_w;
  logic [XW-1:0]     prod_x;
  logic [AREA_W-1:0] prod_sat;

  hmem_ctl_t         h_ctl;
  logic [IW-1:0]     h_rd_addr;
  logic [HW-1:0]     h_rd;
  logic [HW-1:0]     h_new;
  logic              h_busy;

  logic              s_wr;
  logic              s_rd;
  logic [SW-1:0]     s_rd_data;
  logic [IW-1:0]     below_idx;
  logic [HW-1:0]     below_h;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RESET;
    end else if (cfg.valid) begin
      num_cols <= cfg.num_cols;
    end
  end

  // effective column count and clamped position
  always_comb begin
    if (num_cols == '0) begin
      cols = CW'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(num_cols);
    end
    cols_m1  = cols - 1'b1;
    pos_c    = (CW'(column_pos) >= cols) ? cols_m1[IW-1:0] : column_pos;
    pos_c_p1 = CW'(pos_c) + 1'b1;
    pos_p1   = CW'(pos) + 1'b1;
  end

  assign cells.ready = (state == S_IDLE);
  assign accept      = cells.valid && cells.ready;

  // height update: saturating count of ones
  always_comb begin
    if (!cell_val) begin
      h_new = '0;
    end else if (h_rd < HW'(MAX_ROWS)) begin
      h_new = h_rd + 1'b1;
    end else begin
      h_new = h_rd;
    end
  end

  // scan column height comes straight from the held memory read
  assign cur_h = h_rd;
  assign nxt_i = cur_i + CW'(1);
  assign more  = (nxt_i < row_n);

  assign h_rd_addr = (state == S_IDLE) ? pos_c :
                     (state == S_RDS)  ? cur_i[IW-1:0] : nxt_i[IW-1:0];

  assign h_ctl.rd_en = accept || (state == S_RDS) || (push && more);
  assign h_ctl.wr_en = (state == S_RDH);
  assign h_ctl.clear = (state == S_OUT) && (!out_valid || result.ready);

  mrect_hmem #(
    .DEPTH (MAX_COLS),
    .AW    (IW),
    .DW    (HW)
  ) u_hmem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (h_ctl),
    .rd_addr (h_rd_addr),
    .wr_addr (pos),
    .wr_data (h_new),
    .rd_data (h_rd),
    .busy    (h_busy)
  );

  // stack control
  assign pop_cond  = (cnt != '0) && (drain || (top_h >= cur_h));
  assign push      = (state == S_CHK) && !pop_cond && !drain;
  assign cnt_m2    = cnt - CW'(2);
  assign s_wr      = push;
  assign s_rd      = (state == S_CHK) && pop_cond && (cnt >= CW'(2));
  assign below_idx = s_rd_data[SW-1:HW];
  assign below_h   = s_rd_data[HW-1:0];
  assign pop_w     = cur_i - CW'(below_idx) - 1'b1;

  mrect_smem #(
    .DEPTH (MAX_COLS),
    .AW    (IW),
    .DW    (SW)
  ) u_smem (
    .clk     (clk),
    .wr_en   (s_wr),
    .wr_addr (cnt[IW-1:0]),
    .wr_data ({cur_i[IW-1:0], cur_h}),
    .rd_en   (s_rd),
    .rd_addr (cnt_m2[IW-1:0]),
    .rd_data (s_rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      column_pos <= '0;
      cnt        <= '0;
      drain      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos      <= pos_c;
            cell_val <= cells.cell_req;
            last     <= cells.last_cell;
            row_end  <= cells.last_cell || (pos_c_p1 >= cols);
            state    <= S_RDH;
          end
        end
        S_RDH: begin
          if (row_end) begin
            column_pos <= '0;
            cur_i      <= '0;
            row_n      <= pos_p1;
            state      <= S_RDS;
          end else begin
            column_pos <= pos_p1[IW-1:0];
            state      <= S_IDLE;
          end
        end
        S_RDS: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (pop_cond) begin
            if (cnt >= CW'(2)) begin
              state <= S_POP;
            end else begin
              prod <= PW'(top_h) * PW'(cur_i);
              cnt  <= '0;
            end
          end else if (!drain) begin
            top_h <= cur_h;
            cnt   <= cnt + 1'b1;
            cur_i <= nxt_i;
            if (!more) begin
              drain <= 1'b1;
            end
          end else begin
            drain <= 1'b0;
            state <= last ? S_OUT : S_IDLE;
          end
        end
        S_POP: begin
          prod  <= PW'(top_h) * PW'(pop_w);
          top_h <= below_h;
          cnt   <= cnt - 1'b1;
          state <= S_CHK;
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            state <= S_CLR;
          end
        end
        S_CLR: begin
          if (!h_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

  // product strobe, in the cycle after each pop
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= (state == S_POP) ||
                    ((state == S_CHK) && pop_cond && (cnt < CW'(2)));
    end
  end

  // best area, saturated
  assign prod_x   = XW'(prod);
  assign prod_sat = (prod_x > XW'(AREA_MAX)) ? AREA_MAX : prod_x[AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (h_ctl.clear) begin
      best <= '0;
    end else if (prod_valid && (prod_sat > best)) begin
      best <= prod_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (h_ctl.clear) begin
      out_valid <= 1'b1;
      out_area  <= best;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid    = out_valid;
  assign result.max_area = out_area;

  // stack depth never exceeds the maximum column count MAX_COLS
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(MAX_COLS))
    else $error("stack depth above column count");

  // between cells the stack is empty
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((cnt == '0) && !drain))
    else $error("stack not empty between cells");

  // heights written back stay within the row limit
  assert property (@(posedge clk) disable iff (rst)
    h_ctl.wr_en |-> (h_new <= HW'(MAX_ROWS)))
    else $error("column height above row limit");

  // a pop with an entry below always reads the stack memory
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(s_rd) && (cnt >= CW'(2))))
    else $error("pop without stack read");

endmodule
